FILE: hdl/spmc_pkg.sv
// Package for the supercapacitor power-path mode controller.
// Holds the codes, field widths, reset values and shared structs. No dependencies.
package spmc_pkg;

    localparam int MODE_W  = 3;
    localparam int TOPO_W  = 2;
    localparam int MV_W    = 16;
    localparam int LIM_W   = 10;
    localparam int BUF_W   = 16;
    localparam int PWR_W   = 14;
    localparam int SP_W    = 15;
    localparam int ACT_W   = 2;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_ALL_OFF  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SELFTEST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHARGE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BOOST    = 3'd4;

    localparam logic [TOPO_W-1:0] TOPO_OFF     = 2'd0;
    localparam logic [TOPO_W-1:0] TOPO_PASS    = 2'd1;
    localparam logic [TOPO_W-1:0] TOPO_CHARGE  = 2'd2;
    localparam logic [TOPO_W-1:0] TOPO_REFRESH = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CHARGE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PASS      = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLOSE_ALL = 2'd3;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [CFG_AW-1:0] REG_BATTERY_LOCK = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CAP_FULL     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CAP_LOW      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_FALLBACK_LIM = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BOOST_TARGET = 3'd4;

    localparam logic [MV_W-1:0]  RST_BATTERY_LOCK = 16'd18000;
    localparam logic [MV_W-1:0]  RST_CAP_FULL     = 16'd15700;
    localparam logic [MV_W-1:0]  RST_CAP_LOW      = 16'd8000;
    localparam logic [LIM_W-1:0] RST_FALLBACK_LIM = 10'd50;
    localparam logic [PWR_W-1:0] RST_BOOST_TARGET = 14'd2200;

    // buffer tier thresholds, joules
    localparam logic [BUF_W-1:0] BUF_EMPTY = 16'd2;
    localparam logic [BUF_W-1:0] BUF_TIER1 = 16'd5;
    localparam logic [BUF_W-1:0] BUF_TIER2 = 16'd10;
    localparam logic [BUF_W-1:0] BUF_TIER3 = 16'd20;
    localparam logic signed [SP_W-1:0] LIM_STEP_DW = 15'sd50;

    typedef struct packed {
        logic [MV_W-1:0]  battery_lock_mv;
        logic [MV_W-1:0]  cap_full_mv;
        logic [MV_W-1:0]  cap_low_mv;
        logic [LIM_W-1:0] fallback_limit_w;
        logic [PWR_W-1:0] boost_target_dw;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TOPO_W-1:0] topology;
        logic [TOPO_W-1:0] prev_topology;
        logic [PWR_W-1:0]  power_target;
    } state_t;

    typedef struct packed {
        logic              operation;
        logic [MODE_W-1:0] req_mode;
        logic [MV_W-1:0]   battery_mv;
        logic [MV_W-1:0]   capacitor_mv;
        logic              link_ok;
        logic [LIM_W-1:0]  power_limit_w;
        logic [BUF_W-1:0]  power_buffer;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0]      current_mode;
        logic [TOPO_W-1:0]      topology;
        logic [PWR_W-1:0]       chassis_target_dw;
        logic signed [SP_W-1:0] charge_setpoint_dw;
        logic                   setpoint_written;
        logic [ACT_W-1:0]       switch_action;
        logic                   switch_arg_from;
        logic                   switch_arg_stop;
    } result_t;

endpackage

FILE: hdl/spmc_cfg_regs.sv
// Configuration register bank for the power-path mode controller.
// Depends on spmc_pkg.
module spmc_cfg_regs
    import spmc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_BATTERY_LOCK: cfg_next.battery_lock_mv  = cfg_wdata;
                REG_CAP_FULL:     cfg_next.cap_full_mv      = cfg_wdata;
                REG_CAP_LOW:      cfg_next.cap_low_mv       = cfg_wdata;
                REG_FALLBACK_LIM: cfg_next.fallback_limit_w = cfg_wdata[LIM_W-1:0];
                REG_BOOST_TARGET: cfg_next.boost_target_dw  = cfg_wdata[PWR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.battery_lock_mv  <= RST_BATTERY_LOCK;
            cfg_reg.cap_full_mv      <= RST_CAP_FULL;
            cfg_reg.cap_low_mv       <= RST_CAP_LOW;
            cfg_reg.fallback_limit_w <= RST_FALLBACK_LIM;
            cfg_reg.boost_target_dw  <= RST_BOOST_TARGET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/spmc_step.sv
// Combinational step of the mode controller: next state and result for one word.
// Depends on spmc_pkg.
module spmc_step
    import spmc_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  state,
    input  item_t   item,
    output state_t  state_next,
    output result_t res
);

    logic [LIM_W-1:0]       limit;
    logic [PWR_W-1:0]       lim_x6;
    logic [PWR_W-1:0]       lim_x10;
    logic signed [SP_W-1:0] lim_x10_s;
    logic                   full;
    logic signed [SP_W-1:0] setpoint;
    logic                   written;
    logic [ACT_W-1:0]       action;
    logic                   arg_from;
    logic                   arg_stop;
    logic [TOPO_W-1:0]      topo_tick;

    assign limit     = item.link_ok ? item.power_limit_w : cfg.fallback_limit_w;
    assign lim_x6    = PWR_W'({4'd0, limit} * 14'd6);
    assign lim_x10   = PWR_W'({4'd0, limit} * 14'd10);
    assign lim_x10_s = signed'({1'b0, lim_x10});
    assign full      = (item.capacitor_mv >= cfg.cap_full_mv) || (item.power_buffer < BUF_EMPTY);

    always_comb begin
        state_next = state;
        setpoint   = '0;
        written    = 1'b0;
        action     = ACT_NONE;
        arg_from   = 1'b0;
        arg_stop   = 1'b0;
        topo_tick  = TOPO_PASS;
        if (item.operation == OP_REQUEST) begin
            if (item.req_mode <= MODE_BOOST) begin
                if (item.req_mode == MODE_ALL_OFF || item.req_mode == MODE_SELFTEST) begin
                    state_next.power_target = '0;
                    state_next.topology     = TOPO_OFF;
                    written = 1'b1;
                    action  = ACT_CLOSE_ALL;
                end
                if (!((item.battery_mv < cfg.battery_lock_mv) && (state.mode == MODE_ALL_OFF))) begin
                    state_next.mode = item.req_mode;
                end
            end
        end else begin
            case (state.mode)
                MODE_CHARGE: begin
                    topo_tick = TOPO_CHARGE;
                    state_next.power_target = lim_x6;
                end
                MODE_BOOST: begin
                    topo_tick = (item.capacitor_mv < cfg.cap_low_mv) ? TOPO_PASS : TOPO_CHARGE;
                    state_next.power_target = cfg.boost_target_dw;
                end
                MODE_ALL_OFF: begin
                    topo_tick = TOPO_OFF;
                    state_next.power_target = '0;
                end
                default: begin
                    topo_tick = TOPO_PASS;
                    state_next.power_target = lim_x10;
                end
            endcase
            state_next.topology      = topo_tick;
            state_next.prev_topology = topo_tick;
            if (topo_tick == TOPO_CHARGE) begin
                if (full) begin
                    setpoint = '0;
                end else if (item.power_buffer < BUF_TIER1) begin
                    setpoint = signed'({1'b0, lim_x6});
                end else if (item.power_buffer < BUF_TIER2) begin
                    setpoint = lim_x10_s - LIM_STEP_DW;
                end else if (item.power_buffer < BUF_TIER3) begin
                    setpoint = lim_x10_s;
                end else begin
                    setpoint = lim_x10_s + LIM_STEP_DW;
                end
                written  = 1'b1;
                action   = ACT_CHARGE;
                arg_from = (state.prev_topology == TOPO_PASS);
                arg_stop = full;
            end else if (state.prev_topology != topo_tick) begin
                written = 1'b1;
                if (topo_tick == TOPO_PASS) begin
                    action   = ACT_PASS;
                    arg_from = (state.prev_topology == TOPO_CHARGE);
                end else begin
                    action = ACT_CLOSE_ALL;
                end
            end
        end
    end

    always_comb begin
        res.current_mode       = state_next.mode;
        res.topology           = state_next.topology;
        res.chassis_target_dw  = state_next.power_target;
        res.charge_setpoint_dw = setpoint;
        res.setpoint_written   = written;
        res.switch_action      = action;
        res.switch_arg_from    = arg_from;
        res.switch_arg_stop    = arg_stop;
    end

endmodule

FILE: hdl/supercap_power_mode_controller_core.sv
// Supercapacitor power-path mode controller, top level.
// Result path: an accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while m_tready is high; the state update in spmc_step is combinational.
// Reset (aresetn low, synchronous): mode normal, topology off, previous topology refresh,
// power target zero, configuration registers to their defaults, both pipeline stages empty.
// Depends on spmc_pkg, spmc_cfg_regs and spmc_step.
module supercap_power_mode_controller_core
    import spmc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // lowest bit up: req_mode[3], battery_mv[16], capacitor_mv[16], link_ok[1],
    // power_limit_w[10], power_buffer[16], zero fill[2]
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation[1]
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // lowest bit up: current_mode[3], topology[2], chassis_target_dw[14],
    // charge_setpoint_dw[15], setpoint_written[1], switch_action[2],
    // switch_arg_from[1], switch_arg_stop[1], zero fill[1]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_accept;

    spmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spmc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.mode          <= MODE_NORMAL;
            state_reg.topology      <= TOPO_OFF;
            state_reg.prev_topology <= TOPO_REFRESH;
            state_reg.power_target  <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.operation     <= s_tuser;
            item_reg.req_mode      <= s_tdata[2:0];
            item_reg.battery_mv    <= s_tdata[18:3];
            item_reg.capacitor_mv  <= s_tdata[34:19];
            item_reg.link_ok       <= s_tdata[35];
            item_reg.power_limit_w <= s_tdata[45:36];
            item_reg.power_buffer  <= s_tdata[61:46];
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       res_reg.switch_arg_stop,
                       res_reg.switch_arg_from,
                       res_reg.switch_action,
                       res_reg.setpoint_written,
                       res_reg.charge_setpoint_dw,
                       res_reg.chassis_target_dw,
                       res_reg.topology,
                       res_reg.current_mode};

    a_no_refresh_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_reg.topology != TOPO_REFRESH)
        else $error("refresh topology reported");

    a_setpoint_only_charge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_reg.charge_setpoint_dw != '0) |-> res_reg.switch_action == ACT_CHARGE)
        else $error("setpoint without charge action");

    a_stalled_item_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("stalled input word lost");

    a_reset_mode: assert property (@(posedge aclk)
        $rose(aresetn) |-> state_reg.mode == MODE_NORMAL && state_reg.prev_topology == TOPO_REFRESH)
        else $error("bad state after reset");

endmodule
